FILE: sv/vertex_normal_accumulator_top_macros.svh
// ----------------------------------------------------------------------------
// Vertex normal accumulator assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define VNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define VNA_NEVER(lbl, cond, msg) \
  `VNA_ASSERT(lbl, !(cond), msg)
`else
`define VNA_ASSERT(lbl, prop, msg)
`define VNA_NEVER(lbl, cond, msg)
`endif

`endif

FILE: sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Sizes, request codes and saturation helpers.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int POS_WIDTH    = 16;
  localparam int SUM_WIDTH    = 48;
  localparam int IDX_W        = 10;
  localparam int IN_POS_W     = 16;
  localparam int OUT_W        = 16;
  localparam int ADDR_W       = $clog2(VERTEX_COUNT);

  localparam int Q_FRAC  = 14;
  localparam int ONE_Q14 = 1 << Q_FRAC;

  // normalized magnitudes have their top bit at MAG_W-1
  localparam int MAG_W  = 30;
  localparam int L2_W   = 2 * MAG_W + 2;
  localparam int LEN_W  = MAG_W + 1;
  localparam int NUM_W  = MAG_W + Q_FRAC + 1;
  localparam int QDIV_W = 16;
  localparam int DVS_W  = LEN_W + QDIV_W - 1;

  localparam int POS_MAX = (1 << (POS_WIDTH - 1)) - 1;

  typedef enum logic [1:0] {
    OP_WRITE_POS   = 2'd0,
    OP_ADD_TRI     = 2'd1,
    OP_READ_NORMAL = 2'd2
  } op_e;

  typedef logic signed [POS_WIDTH-1:0]     pos_t;
  typedef logic signed [POS_WIDTH:0]       edge_t;
  typedef logic signed [2*POS_WIDTH+1:0]   prod_t;
  typedef logic signed [2*POS_WIDTH+2:0]   cross_t;
  typedef logic signed [SUM_WIDTH-1:0]     sum_t;
  typedef logic [2:0][POS_WIDTH-1:0]       pos_word_t;
  typedef logic [2:0][SUM_WIDTH-1:0]       sum_word_t;

  // Clamp an input coordinate to the stored position range.
  function automatic pos_t sat_pos(logic signed [IN_POS_W-1:0] v);
    logic signed [24:0] w;
    w = 25'(v);
    if (w > 25'(POS_MAX)) w = 25'(POS_MAX);
    if (w < -25'(POS_MAX) - 25'sd1) w = -25'(POS_MAX) - 25'sd1;
    return pos_t'(w);
  endfunction

  // Add a face normal component to a sum, clamping at the sum range.
  function automatic sum_t sat_add(sum_t s, cross_t d);
    logic signed [SUM_WIDTH:0] t;
    t = $signed({s[SUM_WIDTH-1], s}) + (SUM_WIDTH+1)'(d);
    if (t[SUM_WIDTH] != t[SUM_WIDTH-1]) begin
      return t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return t[SUM_WIDTH-1:0];
  endfunction

endpackage

FILE: sv/vertex_normal_accumulator_top.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Position and normal-sum tables with triangle accumulation and unit readout.
// ----------------------------------------------------------------------------
// One request at a time. After reset the block sweeps the sum memory to zero,
// one entry per cycle, with in_ready_o low. After a request is accepted,
// in_ready_o stays low while it is carried out:
// - A position write needs no further steps, so the next request can be taken
//   on the following cycle.
// - A triangle with all corners in range makes three reads of the single-port
//   position memory, then a capture, an edge, a multiply and a cross stage,
//   then a read and a write-back of the single-port sum memory per corner.
// - A normal read makes a sum read and a check, up to 29 one-bit normalizing
//   shifts plus a step to see them done, 3 squaring steps on one multiplier,
//   31 steps of the bit-serial square root, a setup step and one step per
//   quotient bit of the restoring divider for each component, and the output
//   state. An all-zero sum or an out-of-range index skips from the check to it.
// The result sits in an output register, so the next request is accepted
// while it waits. A read that finishes while the previous result is still
// waiting holds in its output state until the register frees.

`include "vertex_normal_accumulator_top_macros.svh"

module vertex_normal_accumulator_top import vna_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [IDX_W-1:0]           index_a_i,
  input  logic [IDX_W-1:0]           index_b_i,
  input  logic [IDX_W-1:0]           index_c_i,
  input  logic signed [IN_POS_W-1:0] pos_x_i,
  input  logic signed [IN_POS_W-1:0] pos_y_i,
  input  logic signed [IN_POS_W-1:0] pos_z_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_W-1:0]    normal_x_o,
  output logic signed [OUT_W-1:0]    normal_y_o,
  output logic signed [OUT_W-1:0]    normal_z_o,
  output logic                       degenerate_o
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_TRI_RD, ST_TRI_CAP, ST_EDGE, ST_MUL, ST_CROSS,
    ST_SUM_RD, ST_SUM_WR, ST_NRM_RD, ST_NRM_CHK, ST_NRM_SHIFT, ST_NRM_SQ,
    ST_NRM_ROOT, ST_NRM_DIV_INIT, ST_NRM_DIV, ST_NRM_OUT
  } state_e;

  localparam logic [L2_W-1:0] BIT_INIT = L2_W'(1) << (L2_W - 2);

  state_e              state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [3:0]          div_cnt_q, div_cnt_d;
  logic                out_valid_q, out_valid_d;

  logic                acc, a_ok, b_ok, c_ok, out_load;

  // memories
  pos_word_t           pos_mem [VERTEX_COUNT];
  sum_word_t           sum_mem [VERTEX_COUNT];
  pos_word_t           pos_rdata_q;
  sum_word_t           sum_rdata_q;
  logic                pos_we, sum_we;
  logic [ADDR_W-1:0]   pos_addr, sum_addr;
  pos_word_t           pos_wdata;
  sum_word_t           sum_wdata;

  // datapath
  logic [ADDR_W-1:0]   corner_q [3];
  logic                rng_q;
  pos_word_t           pos_q [3];
  edge_t               e1_q [3];
  edge_t               e2_q [3];
  prod_t               prod_q [6];
  cross_t              n_q [3];
  logic [SUM_WIDTH-1:0] mag_q [3];
  logic [SUM_WIDTH-1:0] m_q;
  logic                sgn_q [3];
  logic [L2_W-1:0]     x_q, r_q, bit_q;
  logic [LEN_W-1:0]    len_q;
  logic [NUM_W-1:0]    rem_q;
  logic [DVS_W-1:0]    dvs_q;
  logic [QDIV_W-1:0]   q_q;
  logic [OUT_W-1:0]    res_q [3];
  logic                degen_q;
  logic [OUT_W-1:0]    nx_q, ny_q, nz_q;
  logic                ndeg_q;

  logic [MAG_W-1:0]    mag_sel;
  logic [2*MAG_W-1:0]  sq;
  logic [L2_W-1:0]     trial;
  logic                root_take;
  logic                div_take;
  logic [QDIV_W-1:0]   q_next;
  sum_word_t           sums_new;
  logic [SUM_WIDTH-1:0] mag_in [3];
  logic [SUM_WIDTH-1:0] m_in;
  logic                sum_zero;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign a_ok       = 32'(index_a_i) < VERTEX_COUNT;
  assign b_ok       = 32'(index_b_i) < VERTEX_COUNT;
  assign c_ok       = 32'(index_c_i) < VERTEX_COUNT;
  assign out_load   = (state_q == ST_NRM_OUT) && (!out_valid_q || out_ready_i);

  assign mag_sel   = mag_q[cnt_q][MAG_W-1:0];
  assign sq        = mag_sel * mag_sel;
  assign trial     = r_q + bit_q;
  assign root_take = (x_q >= trial);
  assign div_take  = (DVS_W'(rem_q) >= dvs_q);
  assign q_next    = {q_q[QDIV_W-2:0], div_take};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sums_new[i] = sat_add($signed(sum_rdata_q[i]), n_q[i]);
      mag_in[i]   = sum_rdata_q[i][SUM_WIDTH-1] ? SUM_WIDTH'(-$signed(sum_rdata_q[i]))
                                                : sum_rdata_q[i];
    end
    m_in = mag_in[0];
    if (mag_in[1] > m_in) m_in = mag_in[1];
    if (mag_in[2] > m_in) m_in = mag_in[2];
    sum_zero = !rng_q || (sum_rdata_q == '0);
  end

  // memory port steering
  always_comb begin
    pos_we    = acc && (opcode_i == OP_WRITE_POS) && a_ok;
    pos_wdata = {sat_pos(pos_z_i), sat_pos(pos_y_i), sat_pos(pos_x_i)};
    pos_addr  = (state_q == ST_TRI_RD) ? corner_q[cnt_q] : ADDR_W'(index_a_i);
    sum_we    = 1'b0;
    sum_wdata = '0;
    sum_addr  = corner_q[cnt_q];
    case (state_q)
      ST_CLEAR: begin
        sum_we   = 1'b1;
        sum_addr = clr_q;
      end
      ST_IDLE: begin
        sum_we   = pos_we;
        sum_addr = ADDR_W'(index_a_i);
      end
      ST_SUM_WR: begin
        sum_we    = 1'b1;
        sum_wdata = sums_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wdata;
    pos_rdata_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_rdata_q <= sum_mem[sum_addr];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(VERTEX_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          cnt_d = '0;
          case (opcode_i)
            OP_ADD_TRI:     if (a_ok && b_ok && c_ok) state_d = ST_TRI_RD;
            OP_READ_NORMAL: state_d = ST_NRM_RD;
            default: ;
          endcase
        end
      end
      ST_TRI_RD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd2) state_d = ST_TRI_CAP;
      end
      ST_TRI_CAP: state_d = ST_EDGE;
      ST_EDGE:    state_d = ST_MUL;
      ST_MUL:     state_d = ST_CROSS;
      ST_CROSS: begin
        cnt_d   = '0;
        state_d = ST_SUM_RD;
      end
      ST_SUM_RD: state_d = ST_SUM_WR;
      ST_SUM_WR: begin
        cnt_d   = cnt_q + 1'b1;
        state_d = (cnt_q == 2'd2) ? ST_IDLE : ST_SUM_RD;
      end
      ST_NRM_RD:  state_d = ST_NRM_CHK;
      ST_NRM_CHK: state_d = sum_zero ? ST_NRM_OUT : ST_NRM_SHIFT;
      ST_NRM_SHIFT: begin
        if (m_q[SUM_WIDTH-1:MAG_W] == '0 && m_q[MAG_W-1]) begin
          cnt_d   = '0;
          state_d = ST_NRM_SQ;
        end
      end
      ST_NRM_SQ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd2) state_d = ST_NRM_ROOT;
      end
      ST_NRM_ROOT: begin
        if (bit_q[0]) begin
          cnt_d   = '0;
          state_d = ST_NRM_DIV_INIT;
        end
      end
      ST_NRM_DIV_INIT: begin
        div_cnt_d = '0;
        state_d   = ST_NRM_DIV;
      end
      ST_NRM_DIV: begin
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == 4'(QDIV_W - 1)) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = (cnt_q == 2'd2) ? ST_NRM_OUT : ST_NRM_DIV_INIT;
        end
      end
      ST_NRM_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      corner_q[0] <= ADDR_W'(index_a_i);
      corner_q[1] <= ADDR_W'(index_b_i);
      corner_q[2] <= ADDR_W'(index_c_i);
      rng_q       <= a_ok;
    end
    case (state_q)
      ST_TRI_RD:  if (cnt_q != 2'd0) pos_q[cnt_q - 2'd1] <= pos_rdata_q;
      ST_TRI_CAP: pos_q[2] <= pos_rdata_q;
      ST_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= edge_t'($signed(pos_q[1][i])) - edge_t'($signed(pos_q[0][i]));
          e2_q[i] <= edge_t'($signed(pos_q[2][i])) - edge_t'($signed(pos_q[0][i]));
        end
      end
      ST_MUL: begin
        prod_q[0] <= e1_q[1] * e2_q[2];
        prod_q[1] <= e1_q[2] * e2_q[1];
        prod_q[2] <= e1_q[2] * e2_q[0];
        prod_q[3] <= e1_q[0] * e2_q[2];
        prod_q[4] <= e1_q[0] * e2_q[1];
        prod_q[5] <= e1_q[1] * e2_q[0];
      end
      ST_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          n_q[i] <= cross_t'(prod_q[2*i]) - cross_t'(prod_q[2*i+1]);
        end
      end
      ST_NRM_CHK: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mag_in[i];
          sgn_q[i] <= sum_rdata_q[i][SUM_WIDTH-1];
        end
        m_q     <= m_in;
        degen_q <= sum_zero;
        res_q[0] <= '0;
        res_q[1] <= OUT_W'(ONE_Q14);
        res_q[2] <= '0;
      end
      ST_NRM_SHIFT: begin
        // one bit per cycle until the largest magnitude tops out at MAG_W-1
        if (m_q[SUM_WIDTH-1:MAG_W] != '0) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (!m_q[MAG_W-1]) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      ST_NRM_SQ: begin
        x_q   <= ((cnt_q == 2'd0) ? '0 : x_q) + L2_W'(sq);
        r_q   <= '0;
        bit_q <= BIT_INIT;
      end
      ST_NRM_ROOT: begin
        if (root_take) begin
          x_q   <= x_q - trial;
          r_q   <= (r_q >> 1) + bit_q;
          len_q <= LEN_W'((r_q >> 1) + bit_q);
        end else begin
          r_q   <= r_q >> 1;
          len_q <= LEN_W'(r_q >> 1);
        end
        bit_q <= bit_q >> 2;
      end
      ST_NRM_DIV_INIT: begin
        // round to nearest: add half the length before dividing
        rem_q <= NUM_W'({mag_sel, {Q_FRAC{1'b0}}}) + NUM_W'(len_q >> 1);
        dvs_q <= DVS_W'(len_q) << (QDIV_W - 1);
        q_q   <= '0;
      end
      ST_NRM_DIV: begin
        if (div_take) rem_q <= NUM_W'(DVS_W'(rem_q) - dvs_q);
        dvs_q <= dvs_q >> 1;
        q_q   <= q_next;
        if (div_cnt_q == 4'(QDIV_W - 1)) begin
          res_q[cnt_q] <= sgn_q[cnt_q] ? OUT_W'(-q_next) : OUT_W'(q_next);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      nx_q   <= res_q[0];
      ny_q   <= res_q[1];
      nz_q   <= res_q[2];
      ndeg_q <= degen_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign degenerate_o = ndeg_q;

  `VNA_ASSERT(a_clear_blocks_input, (state_q == ST_CLEAR) |-> !in_ready_o, "request accepted during sum clear")
  `VNA_ASSERT(a_degen_up, (out_valid_o && degenerate_o) |-> (normal_x_o == '0 && normal_y_o == OUT_W'(ONE_Q14) && normal_z_o == '0), "degenerate result is not the up vector")
  `VNA_NEVER(a_norm_range, out_valid_o && (normal_x_o > 16'sd16384 || normal_x_o < -16'sd16384), "normal x component beyond unit range")

endmodule

FILE: verif/vertex_normal_accumulator_top_test.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives position writes, triangle adds and normal reads with random gaps on
// both handshakes, predicts every unit normal from a local copy of the vertex
// and sum tables, and compares each returned normal field by field.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top_test;
  import vna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         CycleLimit = 1000000;
  localparam int         DrainWait  = 200;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degen;
  } normal_t;

  class normal_scoreboard;
    int        pos_tab[VERTEX_COUNT][3];
    longint    sum_tab[VERTEX_COUNT][3];
    normal_t   pending_normals[$];
    int        mismatches;

    function new();
      foreach (pos_tab[i, k]) begin
        pos_tab[i][k] = 0;
        sum_tab[i][k] = 0;
      end
      mismatches = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    function longint clamp_sum(longint s, longint d);
      longint hi;
      longint t;
      hi = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
      t  = s + d;
      if (t > hi) t = hi;
      if (t < -hi - 1) t = -hi - 1;
      return t;
    endfunction

    function logic [63:0] int_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function normal_t unit_normal(int v);
      normal_t     n;
      logic [63:0] mag[3];
      logic [63:0] m;
      logic [63:0] l2;
      logic [63:0] len;
      logic [63:0] q;
      int          p;
      m = 0;
      if (sum_tab[v][0] == 0 && sum_tab[v][1] == 0 && sum_tab[v][2] == 0) begin
        n.nx = '0;
        n.ny = OUT_W'(ONE_Q14);
        n.nz = '0;
        n.degen = 1'b1;
        return n;
      end
      for (int k = 0; k < 3; k++) begin
        mag[k] = sum_tab[v][k] < 0 ? 64'(-sum_tab[v][k]) : 64'(sum_tab[v][k]);
        if (mag[k] > m) m = mag[k];
      end
      p = 63;
      while (!m[p]) p--;
      // bring the largest magnitude up or down to bit 29
      for (int k = 0; k < 3; k++) begin
        if (p > 29) mag[k] = mag[k] >> (p - 29);
        else mag[k] = mag[k] << (29 - p);
      end
      l2  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = int_root(l2);
      for (int k = 0; k < 3; k++) begin
        q = (mag[k] * ONE_Q14 + len / 2) / len;
        if (sum_tab[v][k] < 0) q = -q;
        if (k == 0) n.nx = q[15:0];
        else if (k == 1) n.ny = q[15:0];
        else n.nz = q[15:0];
      end
      n.degen = 1'b0;
      return n;
    endfunction

    function void note_request(logic [1:0] op, int a, int b, int c, int x, int y, int z);
      longint e1[3];
      longint e2[3];
      longint cr[3];
      int     corner[3];
      case (op)
        OP_WRITE_POS: begin
          pos_tab[a][0] = x;
          pos_tab[a][1] = y;
          pos_tab[a][2] = z;
          for (int k = 0; k < 3; k++) sum_tab[a][k] = 0;
        end
        OP_ADD_TRI: begin
          for (int k = 0; k < 3; k++) begin
            e1[k] = longint'(pos_tab[b][k]) - pos_tab[a][k];
            e2[k] = longint'(pos_tab[c][k]) - pos_tab[a][k];
          end
          cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
          cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
          cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
          corner[0] = a;
          corner[1] = b;
          corner[2] = c;
          // repeated corners pick up the face twice
          for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
              sum_tab[corner[i]][k] = clamp_sum(sum_tab[corner[i]][k], cr[k]);
        end
        OP_READ_NORMAL: pending_normals = {pending_normals, unit_normal(a)};
        default: ;
      endcase
    endfunction

    task check_result(normal_t got);
      normal_t want;
      if (pending_normals.size() == 0) begin
        report("unexpected normal", got.nx, 0);
        return;
      end
      want = pending_normals.pop_front();
      if (got.nx !== want.nx) report("normal_x", got.nx, want.nx);
      if (got.ny !== want.ny) report("normal_y", got.ny, want.ny);
      if (got.nz !== want.nz) report("normal_z", got.nz, want.nz);
      if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 opcode_i;
  logic [IDX_W-1:0]           index_a_i;
  logic [IDX_W-1:0]           index_b_i;
  logic [IDX_W-1:0]           index_c_i;
  logic signed [IN_POS_W-1:0] pos_x_i;
  logic signed [IN_POS_W-1:0] pos_y_i;
  logic signed [IN_POS_W-1:0] pos_z_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [OUT_W-1:0]    normal_x_o;
  logic signed [OUT_W-1:0]    normal_y_o;
  logic signed [OUT_W-1:0]    normal_z_o;
  logic                       degenerate_o;

  normal_scoreboard sb = new();
  int               vpool[16];
  int               cycles;
  bit               random_phase;

  vertex_normal_accumulator_top dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and hold it until accepted, then idle for a random gap.
  task automatic send(logic [1:0] op, int a, int b, int c, int x, int y, int z);
    int gap;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    index_a_i  <= IDX_W'(a);
    index_b_i  <= IDX_W'(b);
    index_c_i  <= IDX_W'(c);
    pos_x_i    <= IN_POS_W'(x);
    pos_y_i    <= IN_POS_W'(y);
    pos_z_i    <= IN_POS_W'(z);
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, a, b, c, x, y, z);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_vertex(int v);
    send(OP_WRITE_POS, v, $urandom_range(0, 1023), $urandom_range(0, 1023),
         int'($signed(16'($urandom))), int'($signed(16'($urandom))),
         int'($signed(16'($urandom))));
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("vertex_normal_accumulator_top_test: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{normal_x_o, normal_y_o, normal_z_o, degenerate_o});
  end

  // Result side: random stalls, and one long hold-off once random traffic runs.
  initial begin
    int  gap;
    bit  held;
    held = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (random_phase && !held) begin
        held = 1;
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    int a;
    int b;
    int c;
    random_phase = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_WRITE_POS;
    index_a_i    = '0;
    index_b_i    = '0;
    index_c_i    = '0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    pos_z_i      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of coordinates and indices, repeated corners, unused opcode
    send(OP_WRITE_POS, 0, 0, 0, -32768, -32768, -32768);
    send(OP_WRITE_POS, 1, 1023, 1023, 32767, -32768, 0);
    send(OP_WRITE_POS, 2, 0, 0, -32768, 32767, 32767);
    send(OP_WRITE_POS, 1023, 0, 0, 0, 0, 0);
    send(OP_READ_NORMAL, 0, 0, 0, 0, 0, 0);
    send(OP_ADD_TRI, 0, 1, 2, 0, 0, 0);
    send(OP_ADD_TRI, 1023, 0, 1, 0, 0, 0);
    send(OP_ADD_TRI, 2, 2, 1, 0, 0, 0);
    send(OP_ADD_TRI, 1, 1023, 1, 0, 0, 0);
    send(OpUnused, 5, 6, 7, 32767, 32767, 32767);
    send(OP_READ_NORMAL, 0, 1023, 1023, -1, -1, -1);
    send(OP_READ_NORMAL, 1, 0, 0, 0, 0, 0);
    send(OP_READ_NORMAL, 2, 0, 0, 0, 0, 0);
    send(OP_READ_NORMAL, 1023, 0, 0, 0, 0, 0);
    send(OP_READ_NORMAL, 700, 0, 0, 0, 0, 0);
    send(OP_WRITE_POS, 0, 0, 0, 256, -256, 1);
    send(OP_READ_NORMAL, 0, 0, 0, 0, 0, 0);

    random_phase = 1;
    for (int n = 0; n < 580; n++) begin
      // refresh the working set of vertices now and then
      if (n % 100 == 0) begin
        foreach (vpool[i]) begin
          vpool[i] = $urandom_range(0, 1023);
          write_vertex(vpool[i]);
        end
      end
      r = $urandom_range(0, 99);
      a = vpool[$urandom_range(0, 15)];
      b = vpool[$urandom_range(0, 15)];
      c = vpool[$urandom_range(0, 15)];
      if (r < 20) write_vertex(a);
      else if (r < 65) send(OP_ADD_TRI, a, b, c, 0, 0, 0);
      else if (r < 88) send(OP_READ_NORMAL, a, 0, 0, 0, 0, 0);
      else if (r < 95) send(OP_READ_NORMAL, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), 0, 0, 0);
      else send(OpUnused, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), 0, 0, 0);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_normals.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("vertex_normal_accumulator_top_test: clean");
    end else begin
      $display("vertex_normal_accumulator_top_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/vna_pkg.sv
sv/vertex_normal_accumulator_top.sv
verif/vertex_normal_accumulator_top_test.sv
